@@ rtl/core/sld_pkg.sv @@
// Shared types and constants for the sync/length frame deframer.
// No dependencies; every other file of the block refers to it by scoped names.
package sld_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int IDX_W  = 6;

  // Header of a frame whose checksum matched, handed from the parser to replay.
  typedef struct packed {
    logic [BYTE_W-1:0] frame_type;
    logic [LEN_W-1:0]  frame_length;
  } sld_frame_t;

endpackage

@@ rtl/core/sld_if.sv @@
// Valid/ready channel interfaces for the received-byte input and the result output.
// Depends on sld_pkg for field widths.
interface sld_in_if;
  logic                      valid;
  logic                      ready;
  logic [sld_pkg::BYTE_W-1:0] rx_byte;
  logic                      resync;

  modport source (output valid, output rx_byte, output resync, input ready);
  modport sink   (input valid, input rx_byte, input resync, output ready);
endinterface

interface sld_out_if;
  logic                      valid;
  logic                      ready;
  logic [sld_pkg::BYTE_W-1:0] frame_type;
  logic [sld_pkg::LEN_W-1:0]  frame_length;
  logic [sld_pkg::BYTE_W-1:0] data_byte;
  logic [sld_pkg::IDX_W-1:0]  byte_index;
  logic                      empty_frame;
  logic                      last;

  modport source (output valid, output frame_type, output frame_length, output data_byte,
                  output byte_index, output empty_frame, output last, input ready);
  modport sink   (input valid, input frame_type, input frame_length, input data_byte,
                  input byte_index, input empty_frame, input last, output ready);
endinterface

@@ rtl/core/sync_length_frame_deframer.sv @@
// Top level of the sync/type/length frame deframer with XOR checksum.
// Depends on sld_pkg, sld_if, sld_store, sld_parser and sld_replay.
//
//   channel    direction  handshake      payload
//   in_chan    in         valid/ready    rx_byte, resync
//   out_chan   out        valid/ready    frame_type, frame_length, data_byte, byte_index,
//                                        empty_frame, last
//   cfg        in         cfg_we         cfg_wdata (sync byte)
//
// Received bytes are taken one per cycle while parsing.
// A matching checksum byte starts a replay; input is held off until the last result is
// loaded into the output register. Each payload result needs a store read, then an output
// register load; an empty frame needs only the output register load.
// Result stalls hold the output register and slow the replay; parsing is not affected
// by a waiting last result. Reset is synchronous and needs no clearing pass.
module sync_length_frame_deframer #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  sld_in_if.sink                     in_chan,
  sld_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [sld_pkg::BYTE_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [sld_pkg::BYTE_W-1:0] SYNC_RESET = 8'd170;

  logic [sld_pkg::BYTE_W-1:0] sync_byte_r;
  logic                       in_fire;
  logic                       busy;
  logic                       start;
  sld_pkg::sld_frame_t        frame;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [sld_pkg::BYTE_W-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [sld_pkg::BYTE_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r <= SYNC_RESET;
    end else if (cfg_we) begin
      sync_byte_r <= cfg_wdata;
    end
  end

  // Writes happen only while parsing and reads only while replaying, so the store
  // never sees both on the same entry in one cycle.
  assign in_chan.ready = !busy;
  assign in_fire       = in_chan.valid && !busy;

  sld_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rx_byte   (in_chan.rx_byte),
    .resync    (in_chan.resync),
    .sync_byte (sync_byte_r),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .start     (start),
    .frame     (frame)
  );

  sld_store #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sld_replay #(
    .AW (AW)
  ) u_replay (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .frame    (frame),
    .rd_data  (rd_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .busy     (busy),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("store written and read in the same cycle");

  a_start_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_chan.ready)
    else $error("input still ready after a frame was accepted for replay");

  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.empty_frame) |->
      (out_chan.last && (out_chan.frame_length == '0) && (out_chan.data_byte == '0)))
    else $error("empty-frame result with wrong fields");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.empty_frame) |->
      ({1'b0, out_chan.byte_index} < out_chan.frame_length))
    else $error("byte index beyond frame length");
`endif

endmodule

@@ rtl/core/sld_store.sv @@
// Payload store: one write port, one read port, registered read data.
// Depends on sld_pkg for the byte width.
module sld_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [sld_pkg::BYTE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [sld_pkg::BYTE_W-1:0] rd_data
);

  logic [sld_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [sld_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/sld_parser.sv @@
// Byte-serial header parser with running XOR check; writes payload bytes to the store.
// Depends on sld_pkg for widths and the frame header type.
module sld_parser #(
  parameter int MAX_PAYLOAD = 64,
  parameter int AW          = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [sld_pkg::BYTE_W-1:0] rx_byte,
  input  logic                       resync,
  input  logic [sld_pkg::BYTE_W-1:0] sync_byte,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [sld_pkg::BYTE_W-1:0] wr_data,
  output logic                       start,
  output sld_pkg::sld_frame_t        frame
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_t;

  localparam logic [sld_pkg::BYTE_W-1:0] MAX_B = sld_pkg::BYTE_W'(MAX_PAYLOAD);

  phase_t                     phase_r, phase_nxt;
  logic [sld_pkg::BYTE_W-1:0] type_r, type_nxt;
  logic [sld_pkg::BYTE_W-1:0] chk_r, chk_nxt;
  logic                       hi_nz_r, hi_nz_nxt;
  logic [sld_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [sld_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [sld_pkg::LEN_W-1:0]  cnt_inc;

  assign cnt_inc = sld_pkg::LEN_W'(cnt_r + 1'b1);

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    chk_nxt   = chk_r;
    hi_nz_nxt = hi_nz_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    start     = 1'b0;
    if (in_fire) begin
      if (resync) begin
        phase_nxt = PH_HUNT;
        type_nxt  = '0;
        chk_nxt   = '0;
        hi_nz_nxt = 1'b0;
        len_nxt   = '0;
        cnt_nxt   = '0;
      end else begin
        case (phase_r)
          PH_TYPE: begin
            type_nxt  = rx_byte;
            chk_nxt   = chk_r ^ rx_byte;
            phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            hi_nz_nxt = (rx_byte != '0);
            chk_nxt   = chk_r ^ rx_byte;
            phase_nxt = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            chk_nxt = chk_r ^ rx_byte;
            // An oversized length drops the frame; the header bytes are not rescanned.
            if (hi_nz_r || (rx_byte > MAX_B)) begin
              phase_nxt = PH_HUNT;
            end else begin
              len_nxt   = rx_byte[sld_pkg::LEN_W-1:0];
              phase_nxt = (rx_byte == '0) ? PH_CHECK : PH_DATA;
            end
          end
          PH_DATA: begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_inc;
            chk_nxt = chk_r ^ rx_byte;
            if (cnt_inc >= len_r) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            start     = (rx_byte == chk_r);
            phase_nxt = PH_HUNT;
          end
          default: begin
            phase_nxt = PH_HUNT;
            if (rx_byte == sync_byte) begin
              phase_nxt = PH_TYPE;
              chk_nxt   = '0;
              cnt_nxt   = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      type_r  <= '0;
      chk_r   <= '0;
      hi_nz_r <= 1'b0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      chk_r   <= chk_nxt;
      hi_nz_r <= hi_nz_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign wr_addr            = cnt_r[AW-1:0];
  assign wr_data            = rx_byte;
  assign frame.frame_type   = type_r;
  assign frame.frame_length = len_r;

endmodule

@@ rtl/core/sld_replay.sv @@
// Replay sequencer: reads the stored payload and drives the registered result channel.
// Depends on sld_pkg and the sld_out_if interface.
module sld_replay #(
  parameter int AW = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  sld_pkg::sld_frame_t        frame,
  input  logic [sld_pkg::BYTE_W-1:0] rd_data,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  output logic                       busy,
  sld_out_if.source                  out_chan
);

  typedef enum logic [1:0] {
    RP_IDLE  = 2'd0,
    RP_EMPTY = 2'd1,
    RP_READ  = 2'd2,
    RP_LOAD  = 2'd3
  } rp_state_t;

  rp_state_t                  state_r;
  sld_pkg::sld_frame_t        frame_r;
  logic [sld_pkg::LEN_W-1:0]  k_r;
  logic                       valid_r;
  logic [sld_pkg::BYTE_W-1:0] type_r;
  logic [sld_pkg::LEN_W-1:0]  length_r;
  logic [sld_pkg::BYTE_W-1:0] data_r;
  logic [sld_pkg::IDX_W-1:0]  index_r;
  logic                       empty_r;
  logic                       last_r;
  logic                       out_free;
  logic                       last_hit;
  logic                       load_out;

  // The output register is free if empty or being taken in this cycle.
  assign out_free = !valid_r || out_chan.ready;
  assign last_hit = (sld_pkg::LEN_W'(k_r + 1'b1) == frame_r.frame_length);
  assign rd_en    = (state_r == RP_READ) && out_free;
  assign rd_addr  = k_r[AW-1:0];
  assign busy     = (state_r != RP_IDLE);
  assign load_out = ((state_r == RP_EMPTY) && out_free) || (state_r == RP_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RP_IDLE;
      valid_r <= 1'b0;
      k_r     <= '0;
    end else begin
      if (load_out) begin
        valid_r <= 1'b1;
      end else if (valid_r && out_chan.ready) begin
        valid_r <= 1'b0;
      end
      case (state_r)
        RP_IDLE: begin
          if (start) begin
            frame_r <= frame;
            k_r     <= '0;
            state_r <= (frame.frame_length == '0) ? RP_EMPTY : RP_READ;
          end
        end
        RP_EMPTY: begin
          if (out_free) begin
            type_r   <= frame_r.frame_type;
            length_r <= '0;
            data_r   <= '0;
            index_r  <= '0;
            empty_r  <= 1'b1;
            last_r   <= 1'b1;
            state_r  <= RP_IDLE;
          end
        end
        RP_READ: begin
          if (out_free) begin
            state_r <= RP_LOAD;
          end
        end
        RP_LOAD: begin
          // The register was freed when the read was issued, so it is empty here.
          type_r   <= frame_r.frame_type;
          length_r <= frame_r.frame_length;
          data_r   <= rd_data;
          index_r  <= k_r[sld_pkg::IDX_W-1:0];
          empty_r  <= 1'b0;
          last_r   <= last_hit;
          k_r      <= sld_pkg::LEN_W'(k_r + 1'b1);
          state_r  <= last_hit ? RP_IDLE : RP_READ;
        end
        default: begin
          state_r <= RP_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.frame_type   = type_r;
  assign out_chan.frame_length = length_r;
  assign out_chan.data_byte    = data_r;
  assign out_chan.byte_index   = index_r;
  assign out_chan.empty_frame  = empty_r;
  assign out_chan.last         = last_r;

endmodule
